@@ rtl/core/fws_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow window sender package
// Shared widths, constants, codes, payload types and the threshold priority
// function of the flow window sender.
// ----------------------------------------------------------------------------
package fws_pkg;

  localparam int NUM_THRESHOLDS = 7;
  localparam int MAX_BURST      = 64;
  localparam int BURST_W        = $clog2(MAX_BURST + 1);

  localparam int SEQ_W      = 32;
  localparam int SEG_W      = 14;
  localparam int HDR_W      = 8;
  localparam int WIN_W      = 6;
  localparam int SSL_W      = 17;
  localparam int MODE_W     = 2;
  localparam int QOS_W      = 8;
  localparam int PRIO_W     = 32;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = WIN_W + SEG_W;
  localparam int LIMIT_W    = SEQ_W + 2;

  localparam logic [SSL_W-1:0]  SSL_RESET   = 17'd100000;
  localparam logic [SSL_W-1:0]  SSL_MIN     = 17'd2;
  localparam logic [PRIO_W-1:0] THRESH_BASE = 32'd4096;
  localparam logic [PRIO_W-1:0] PRIO_ONE    = 32'd1;

  localparam logic [SEQ_W-1:0]  FLOW_BYTES_RST   = 32'd1;
  localparam logic [SEG_W-1:0]  SEGMENT_BYTES_RST = 14'd1460;
  localparam logic [HDR_W-1:0]  HEADER_BYTES_RST = 8'd40;
  localparam logic [WIN_W-1:0]  WINDOW_CAP_RST   = 6'd63;
  localparam logic [WIN_W-1:0]  INIT_WINDOW_RST  = 6'd1;
  localparam logic [QOS_W-1:0]  QOS_LEVEL_RST    = 8'd0;

  localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACK     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

  localparam logic [MODE_W-1:0] PM_REMAINING = 2'd0;
  localparam logic [MODE_W-1:0] PM_THRESHOLD = 2'd1;
  localparam logic [MODE_W-1:0] PM_QOS       = 2'd2;
  localparam logic [MODE_W-1:0] PM_ONE       = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_BYTES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BYTES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_CAP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WINDOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_MODE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_QOS_LEVEL      = 3'd6;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [SEQ_W-1:0] ack_seq;
  } in_item_t;

  typedef struct packed {
    logic              pkt_valid;
    logic [SEQ_W-1:0]  pkt_seq;
    logic [SEG_W-1:0]  pkt_bytes;
    logic [PRIO_W-1:0] pkt_priority;
    logic              flow_done;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LIMIT,
    ST_CHECK,
    ST_EMIT,
    ST_EMPTY
  } fsm_state_t;

  typedef struct packed {
    logic apply_event;
    logic mul;
    logic limit;
    logic load_seg;
    logic load_empty;
  } ctrl_cmd_t;

  typedef struct packed {
    logic first_ok;
    logic next_ok;
  } ctrl_sts_t;

  function automatic logic [PRIO_W-1:0] threshold_priority(input logic [SEQ_W-1:0] remaining);
    logic [PRIO_W-1:0] result;
    result = PRIO_W'(NUM_THRESHOLDS);
    for (int i = NUM_THRESHOLDS - 1; i >= 0; i--) begin
      if (remaining <= (THRESH_BASE << i)) begin
        result = PRIO_W'(i);
      end
    end
    return result;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fws_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow window sender controller
// Sequences event setup and segment emission and owns the valid flag of the
// output register.
// ----------------------------------------------------------------------------
module fws_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire fws_pkg::ctrl_sts_t sts,
  output fws_pkg::ctrl_cmd_t     cmd
);

  fws_pkg::fsm_state_t state;
  fws_pkg::fsm_state_t state_next;
  logic                out_valid_next;
  logic                slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fws_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      fws_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.apply_event = 1'b1;
          state_next      = fws_pkg::ST_MUL;
        end
      end
      fws_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = fws_pkg::ST_LIMIT;
      end
      fws_pkg::ST_LIMIT: begin
        cmd.limit  = 1'b1;
        state_next = fws_pkg::ST_CHECK;
      end
      fws_pkg::ST_CHECK: begin
        state_next = sts.first_ok ? fws_pkg::ST_EMIT : fws_pkg::ST_EMPTY;
      end
      fws_pkg::ST_EMIT: begin
        if (slot_free) begin
          cmd.load_seg = 1'b1;
          if (!sts.next_ok) begin
            state_next = fws_pkg::ST_IDLE;
          end
        end
      end
      fws_pkg::ST_EMPTY: begin
        if (slot_free) begin
          cmd.load_empty = 1'b1;
          state_next     = fws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fws_pkg::ST_IDLE;
      end
    endcase
    if (cmd.load_seg || cmd.load_empty) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/fws_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow window sender datapath
// Holds the configuration, sequence and window state, computes the send limit
// and priority, and builds each result in the output register.
// ----------------------------------------------------------------------------
module fws_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire fws_pkg::in_item_t                  in_data,
  input  wire logic                               cfg_valid,
  input  wire logic [fws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fws_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire fws_pkg::ctrl_cmd_t                 cmd,
  output fws_pkg::ctrl_sts_t                      sts,
  output fws_pkg::out_item_t                      out_data
);

  logic [fws_pkg::SEQ_W-1:0]   flow_bytes;
  logic [fws_pkg::SEG_W-1:0]   segment_bytes;
  logic [fws_pkg::HDR_W-1:0]   header_bytes;
  logic [fws_pkg::WIN_W-1:0]   window_cap;
  logic [fws_pkg::WIN_W-1:0]   initial_window;
  logic [fws_pkg::MODE_W-1:0]  priority_mode;
  logic [fws_pkg::QOS_W-1:0]   qos_level;

  logic [fws_pkg::SEQ_W-1:0]   next_offset;
  logic [fws_pkg::SEQ_W-1:0]   oldest_unacked;
  logic [fws_pkg::WIN_W-1:0]   window_segments;
  logic [fws_pkg::SSL_W-1:0]   slow_start_limit;
  logic [fws_pkg::WIN_W-1:0]   increase_count;
  logic                        done_flag;
  logic                        emit_en;

  logic [fws_pkg::PROD_W-1:0]  product;
  logic [fws_pkg::SEG_W:0]     two_mss;
  logic [fws_pkg::LIMIT_W-1:0] limit;
  logic [fws_pkg::PRIO_W-1:0]  prio;
  logic [fws_pkg::BURST_W-1:0] count;

  logic [fws_pkg::SEG_W-1:0]   mss;
  logic [fws_pkg::SEQ_W-1:0]   remaining;
  logic [fws_pkg::PRIO_W-1:0]  prio_pick;
  logic [fws_pkg::WIN_W:0]     win_grown;
  logic [fws_pkg::WIN_W-1:0]   ic_grown;
  logic [fws_pkg::WIN_W-1:0]   ic_inc;
  logic [fws_pkg::WIN_W-1:0]   half_window;
  logic [fws_pkg::LIMIT_W-1:0] size_w;
  logic [fws_pkg::LIMIT_W-1:0] seg_end;
  logic [fws_pkg::LIMIT_W-1:0] seg_end2;
  logic [fws_pkg::SEG_W-1:0]   pay_bytes;
  logic [fws_pkg::SEQ_W-1:0]   tail_bytes;
  logic [fws_pkg::BURST_W-1:0] count_inc;

  assign mss         = (segment_bytes == '0) ? fws_pkg::SEG_W'(1) : segment_bytes;
  assign remaining   = flow_bytes - oldest_unacked;
  assign half_window = window_segments >> 1;
  assign size_w      = fws_pkg::LIMIT_W'(flow_bytes);
  assign seg_end     = fws_pkg::LIMIT_W'(next_offset) + fws_pkg::LIMIT_W'(mss);
  assign seg_end2    = fws_pkg::LIMIT_W'(next_offset) + fws_pkg::LIMIT_W'(two_mss);
  assign tail_bytes  = flow_bytes - next_offset;
  assign pay_bytes   = (seg_end > size_w) ? tail_bytes[fws_pkg::SEG_W-1:0] : mss;
  assign count_inc   = count + fws_pkg::BURST_W'(1);

  assign sts.first_ok = emit_en && (next_offset < flow_bytes) && (seg_end <= limit);
  assign sts.next_ok  = (count_inc < fws_pkg::BURST_W'(fws_pkg::MAX_BURST))
                     && (seg_end < size_w) && (seg_end2 <= limit);

  always_comb begin
    unique case (priority_mode)
      fws_pkg::PM_REMAINING: prio_pick = remaining;
      fws_pkg::PM_THRESHOLD: prio_pick = fws_pkg::threshold_priority(remaining);
      fws_pkg::PM_QOS:       prio_pick = fws_pkg::PRIO_W'(qos_level);
      fws_pkg::PM_ONE:       prio_pick = fws_pkg::PRIO_ONE;
      default:               prio_pick = fws_pkg::PRIO_ONE;
    endcase
  end

  always_comb begin
    ic_inc   = increase_count + fws_pkg::WIN_W'(1);
    ic_grown = increase_count;
    if (fws_pkg::SSL_W'(window_segments) < slow_start_limit) begin
      win_grown = {1'b0, window_segments} + (fws_pkg::WIN_W+1)'(1);
    end else if (ic_inc >= window_segments) begin
      ic_grown  = '0;
      win_grown = {1'b0, window_segments} + (fws_pkg::WIN_W+1)'(1);
    end else begin
      ic_grown  = ic_inc;
      win_grown = {1'b0, window_segments};
    end
    if (win_grown > {1'b0, window_cap}) begin
      win_grown = {1'b0, window_cap};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_bytes     <= fws_pkg::FLOW_BYTES_RST;
      segment_bytes  <= fws_pkg::SEGMENT_BYTES_RST;
      header_bytes   <= fws_pkg::HEADER_BYTES_RST;
      window_cap     <= fws_pkg::WINDOW_CAP_RST;
      initial_window <= fws_pkg::INIT_WINDOW_RST;
      priority_mode  <= fws_pkg::PM_REMAINING;
      qos_level      <= fws_pkg::QOS_LEVEL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fws_pkg::CFG_FLOW_BYTES:     flow_bytes     <= cfg_data[fws_pkg::SEQ_W-1:0];
        fws_pkg::CFG_SEGMENT_BYTES:  segment_bytes  <= cfg_data[fws_pkg::SEG_W-1:0];
        fws_pkg::CFG_HEADER_BYTES:   header_bytes   <= cfg_data[fws_pkg::HDR_W-1:0];
        fws_pkg::CFG_WINDOW_CAP:     window_cap     <= cfg_data[fws_pkg::WIN_W-1:0];
        fws_pkg::CFG_INITIAL_WINDOW: initial_window <= cfg_data[fws_pkg::WIN_W-1:0];
        fws_pkg::CFG_PRIORITY_MODE:  priority_mode  <= cfg_data[fws_pkg::MODE_W-1:0];
        fws_pkg::CFG_QOS_LEVEL:      qos_level      <= cfg_data[fws_pkg::QOS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_offset      <= '0;
      oldest_unacked   <= '0;
      window_segments  <= fws_pkg::INIT_WINDOW_RST;
      slow_start_limit <= fws_pkg::SSL_RESET;
      increase_count   <= '0;
      done_flag        <= 1'b0;
      emit_en          <= 1'b0;
    end else if (cmd.apply_event) begin
      unique case (in_data.req_type)
        fws_pkg::REQ_START: begin
          next_offset      <= '0;
          oldest_unacked   <= '0;
          window_segments  <= initial_window;
          slow_start_limit <= fws_pkg::SSL_RESET;
          increase_count   <= '0;
          done_flag        <= 1'b0;
          emit_en          <= 1'b1;
        end
        fws_pkg::REQ_ACK: begin
          if (next_offset < in_data.ack_seq) begin
            next_offset <= in_data.ack_seq;
          end
          if (in_data.ack_seq > oldest_unacked) begin
            oldest_unacked  <= in_data.ack_seq;
            window_segments <= win_grown[fws_pkg::WIN_W-1:0];
            increase_count  <= ic_grown;
            emit_en         <= 1'b1;
          end else begin
            emit_en <= 1'b0;
          end
          if (in_data.ack_seq == flow_bytes) begin
            done_flag <= 1'b1;
          end
        end
        fws_pkg::REQ_TIMEOUT: begin
          slow_start_limit <= (fws_pkg::SSL_W'(half_window) < fws_pkg::SSL_MIN)
                            ? fws_pkg::SSL_MIN : fws_pkg::SSL_W'(half_window);
          next_offset      <= oldest_unacked;
          window_segments  <= initial_window;
          emit_en          <= 1'b1;
        end
        default: begin
          emit_en <= 1'b0;
        end
      endcase
    end else if (cmd.load_seg) begin
      next_offset <= (seg_end < size_w) ? seg_end[fws_pkg::SEQ_W-1:0] : flow_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      product <= fws_pkg::PROD_W'(window_segments) * fws_pkg::PROD_W'(mss);
      two_mss <= {mss, 1'b0};
      prio    <= prio_pick;
    end
    if (cmd.limit) begin
      limit <= fws_pkg::LIMIT_W'(oldest_unacked) + fws_pkg::LIMIT_W'(product);
    end
    if (cmd.mul) begin
      count <= '0;
    end else if (cmd.load_seg) begin
      count <= count_inc;
    end
    if (cmd.load_seg) begin
      out_data.pkt_valid    <= 1'b1;
      out_data.pkt_seq      <= next_offset;
      out_data.pkt_bytes    <= fws_pkg::SEG_W'({1'b0, pay_bytes}
                                + (fws_pkg::SEG_W+1)'(header_bytes));
      out_data.pkt_priority <= prio;
      out_data.flow_done    <= done_flag;
      out_data.last         <= !sts.next_ok;
    end else if (cmd.load_empty) begin
      out_data.pkt_valid    <= 1'b0;
      out_data.pkt_seq      <= '0;
      out_data.pkt_bytes    <= '0;
      out_data.pkt_priority <= '0;
      out_data.flow_done    <= done_flag;
      out_data.last         <= 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/flow_window_sender_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow window sender core
// Sender side of one window-controlled flow with per-packet priority.
//
// The input channel takes one event per transaction: start, cumulative ack
// or retransmit timeout. The output channel returns one transaction per
// segment the window releases, the final one of an event marked by last; an
// event that releases nothing returns a single result with pkt_valid low.
// The configuration channel is always ready; the user must see that it is
// written only while the block is idle, as the block does not enforce this.
// After an event is accepted, three setup states run (window times segment
// size, send limit, first check), then the first result is loaded once the
// output register is free. Segments follow one per cycle from the output
// register while the receiver takes them, at most 64 per event. A stalled
// receiver holds the output register and pauses emission; the next event
// is accepted as soon as the last result is loaded. Reset restores the
// state and configuration registers to reset values and empties the output.
// ----------------------------------------------------------------------------
module flow_window_sender_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire fws_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output fws_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fws_pkg::CFG_DATA_W-1:0] cfg_data
);

  fws_pkg::ctrl_cmd_t cmd;
  fws_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  fws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fws_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ rtl/core/fws_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow window sender checker
// Port-level assertions on the result stream and event acceptance, bound to the top level.
// ----------------------------------------------------------------------------
module fws_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire fws_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Output transaction changed while stalled.");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.pkt_valid |-> out_data.last)
    else $error("No-packet result without last marker.");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.pkt_valid |->
      out_data.pkt_seq == '0 && out_data.pkt_bytes == '0 && out_data.pkt_priority == '0)
    else $error("No-packet result carries nonzero fields.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_event_done: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !(out_valid && !out_data.last))
    else $error("Event accepted while a burst is unfinished.");

endmodule

bind flow_window_sender_core fws_checker u_fws_checker (.*);
`default_nettype wire

@@ verif/flow_window_sender_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow window sender checker
// Watches the event, result and register channels of the flow window sender.
// It keeps its own copy of the sequence state, the congestion window and the
// registers, and predicts the segments that each accepted event releases.
// Every accepted result is compared field by field with the oldest prediction.
// The count of outstanding predictions and of failures goes to the top.
// ----------------------------------------------------------------------------
module flow_window_sender_checker
  import fws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending,
  output int                    errors
);

  logic [SEQ_W-1:0]  cfg_flow;
  logic [SEG_W-1:0]  cfg_seg;
  logic [HDR_W-1:0]  cfg_hdr;
  logic [WIN_W-1:0]  cfg_cap;
  logic [WIN_W-1:0]  cfg_init;
  logic [MODE_W-1:0] cfg_mode;
  logic [QOS_W-1:0]  cfg_qos;

  logic [63:0]      next_off;
  logic [63:0]      una;
  logic [WIN_W-1:0] cwnd;
  logic [SSL_W-1:0] ssthresh;
  logic [WIN_W-1:0] ca_count;
  logic             finished;

  out_item_t expected_segments[$];
  out_item_t want;
  int        fail_count = 0;

  function automatic logic [PRIO_W-1:0] segment_priority();
    logic [SEQ_W-1:0] remaining;
    remaining = SEQ_W'(64'(cfg_flow) - una);
    case (cfg_mode)
      PM_REMAINING: return remaining;
      PM_THRESHOLD: begin
        for (int i = 0; i < NUM_THRESHOLDS; i++) begin
          if (remaining <= (THRESH_BASE << i)) return PRIO_W'(i);
        end
        return PRIO_W'(NUM_THRESHOLDS);
      end
      PM_QOS: return PRIO_W'(cfg_qos);
      default: return PRIO_ONE;
    endcase
  endfunction

  task automatic restart_flow();
    next_off = '0;
    una      = '0;
    cwnd     = cfg_init;
    ssthresh = SSL_RESET;
    ca_count = '0;
    finished = 1'b0;
  endtask

  task automatic open_window();
    int unsigned w;
    w = cwnd;
    if (w < ssthresh) begin
      w++;
    end else begin
      ca_count = ca_count + 1'b1;
      if (ca_count >= w) begin
        ca_count = '0;
        w++;
      end
    end
    if (w > cfg_cap) w = cfg_cap;
    cwnd = WIN_W'(w);
  endtask

  task automatic release_segments(ref out_item_t burst[$]);
    logic [63:0] mss;
    logic [63:0] limit;
    logic [63:0] seq;
    logic [63:0] len;
    out_item_t   item;
    int          n;
    mss   = (cfg_seg == '0) ? 64'd1 : 64'(cfg_seg);
    limit = una + 64'(cwnd) * mss;
    seq   = next_off;
    n     = 0;
    while (n < MAX_BURST && seq < 64'(cfg_flow) && seq + mss <= limit) begin
      len = (seq + mss > 64'(cfg_flow)) ? 64'(cfg_flow) - seq : mss;
      item = '0;
      item.pkt_valid    = 1'b1;
      item.pkt_seq      = SEQ_W'(seq);
      item.pkt_bytes    = SEG_W'(len + 64'(cfg_hdr));
      item.pkt_priority = segment_priority();
      burst.push_back(item);
      seq = (seq + mss < 64'(cfg_flow)) ? seq + mss : 64'(cfg_flow);
      next_off = seq;
      n++;
    end
  endtask

  task automatic apply_event(input in_item_t ev);
    out_item_t   burst[$];
    int unsigned half;
    case (ev.req_type)
      REQ_START: begin
        restart_flow();
        release_segments(burst);
      end
      REQ_ACK: begin
        if (next_off < 64'(ev.ack_seq)) next_off = 64'(ev.ack_seq);
        if (64'(ev.ack_seq) > una) begin
          una = 64'(ev.ack_seq);
          open_window();
          release_segments(burst);
        end
        if (ev.ack_seq == cfg_flow) finished = 1'b1;
      end
      REQ_TIMEOUT: begin
        half     = cwnd / 2;
        ssthresh = (half < 2) ? SSL_MIN : SSL_W'(half);
        next_off = una;
        cwnd     = cfg_init;
        release_segments(burst);
      end
      default: begin
      end
    endcase
    if (burst.size() == 0) burst.push_back('0);
    foreach (burst[k]) begin
      burst[k].flow_done = finished;
      burst[k].last      = (k == burst.size() - 1);
      expected_segments.push_back(burst[k]);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_flow = FLOW_BYTES_RST;
      cfg_seg  = SEGMENT_BYTES_RST;
      cfg_hdr  = HEADER_BYTES_RST;
      cfg_cap  = WINDOW_CAP_RST;
      cfg_init = INIT_WINDOW_RST;
      cfg_mode = PM_REMAINING;
      cfg_qos  = QOS_LEVEL_RST;
      restart_flow();
      expected_segments.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_segments.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
        end else begin
          want = expected_segments.pop_front();
          check_field("pkt_valid", want.pkt_valid, out_data.pkt_valid);
          check_field("pkt_seq", want.pkt_seq, out_data.pkt_seq);
          check_field("pkt_bytes", want.pkt_bytes, out_data.pkt_bytes);
          check_field("pkt_priority", want.pkt_priority, out_data.pkt_priority);
          check_field("flow_done", want.flow_done, out_data.flow_done);
          check_field("last", want.last, out_data.last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FLOW_BYTES:     cfg_flow = cfg_data;
          CFG_SEGMENT_BYTES:  cfg_seg  = cfg_data[SEG_W-1:0];
          CFG_HEADER_BYTES:   cfg_hdr  = cfg_data[HDR_W-1:0];
          CFG_WINDOW_CAP:     cfg_cap  = cfg_data[WIN_W-1:0];
          CFG_INITIAL_WINDOW: cfg_init = cfg_data[WIN_W-1:0];
          CFG_PRIORITY_MODE:  cfg_mode = cfg_data[MODE_W-1:0];
          CFG_QOS_LEVEL:      cfg_qos  = cfg_data[QOS_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) apply_event(in_data);
    end
    pending <= expected_segments.size();
    errors  <= fail_count;
  end

endmodule

@@ verif/tb_flow_window_sender_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow window sender testbench
// Drives start, ack and timeout events into the flow window sender under
// several register settings, first a short directed set of corner cases and
// then randomized flows made mostly of acks on segment boundaries, mixed with
// timeouts, stray acks, unused event codes and restarts. Both channels idle
// at random, except in two of the random flows, which run without gaps. A
// checker beside the block predicts and compares every result; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_flow_window_sender_core;
  import fws_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_EVENTS = 350;
  localparam int unsigned DRAIN_CYCLES  = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  cfg_ready;
  out_item_t             out_data;
  int                    pending;
  int                    errors;

  int          in_idle_pct  = 32;
  int          out_idle_pct = 32;
  int unsigned events_sent  = 0;
  int unsigned cycles       = 0;
  logic [SEQ_W-1:0] flow_size = FLOW_BYTES_RST;
  logic [63:0]      seg_size  = 64'(SEGMENT_BYTES_RST);
  logic [63:0]      sent_end  = '0;
  logic [63:0]      acked     = '0;
  logic [63:0]      seg_end;

  always #4 clk = ~clk;

  flow_window_sender_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  flow_window_sender_checker segment_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  assign seg_end = (64'(out_data.pkt_seq) + seg_size < 64'(flow_size)) ?
                   64'(out_data.pkt_seq) + seg_size : 64'(flow_size);

  // Highest byte sent so far in the current flow, used to build sensible acks.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready && in_data.req_type == REQ_START)) begin
      sent_end <= '0;
    end else if (out_valid && out_ready && out_data.pkt_valid &&
                 out_data.pkt_seq < flow_size && seg_end > sent_end) begin
      sent_end <= seg_end;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [SEQ_W-1:0] fbytes, input logic [SEG_W-1:0] mss,
                           input logic [HDR_W-1:0] hdr, input logic [WIN_W-1:0] cap,
                           input logic [WIN_W-1:0] init, input logic [MODE_W-1:0] mode,
                           input logic [QOS_W-1:0] qos);
    write_reg(CFG_FLOW_BYTES, CFG_DATA_W'(fbytes));
    write_reg(CFG_SEGMENT_BYTES, CFG_DATA_W'(mss));
    write_reg(CFG_HEADER_BYTES, CFG_DATA_W'(hdr));
    write_reg(CFG_WINDOW_CAP, CFG_DATA_W'(cap));
    write_reg(CFG_INITIAL_WINDOW, CFG_DATA_W'(init));
    write_reg(CFG_PRIORITY_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_QOS_LEVEL, CFG_DATA_W'(qos));
    cfg_valid <= 1'b0;
    flow_size = fbytes;
    seg_size  = (mss == '0) ? 64'd1 : 64'(mss);
  endtask

  // Leaves valid high after the transaction so back-to-back events need no gap.
  task automatic post(input logic [REQ_W-1:0] req, input logic [SEQ_W-1:0] ack);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= {req, ack};
    if (req == REQ_START) acked = '0;
    else if (req == REQ_ACK && 64'(ack) > acked) acked = 64'(ack);
    events_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_flow();
    int unsigned      r;
    int unsigned      n_ev;
    int unsigned      k;
    logic [SEG_W-1:0] mss;
    logic [63:0]      mss_eff;
    logic [63:0]      span;
    logic [63:0]      ack;
    logic [SEQ_W-1:0] fbytes;
    logic [WIN_W-1:0] cap;
    logic [WIN_W-1:0] init;
    r = $urandom_range(99);
    if (r < 70) mss = SEG_W'($urandom_range(1, 1500));
    else if (r < 85) mss = SEG_W'($urandom_range(1501, 9000));
    else if (r < 95) mss = SEG_W'($urandom_range(9001, 16383));
    else mss = '0;
    mss_eff = (mss == '0) ? 64'd1 : 64'(mss);
    r = $urandom_range(99);
    if (r < 50) begin
      fbytes = SEQ_W'(mss_eff * $urandom_range(1, 12) - $urandom_range(0, mss_eff - 1));
    end else if (r < 88) begin
      fbytes = SEQ_W'(mss_eff * $urandom_range(13, 60) - $urandom_range(0, mss_eff - 1));
    end else begin
      fbytes = $urandom;
    end
    r = $urandom_range(99);
    if (r < 10) cap = 6'd63;
    else if (r < 15) cap = 6'd1;
    else if (r < 18) cap = 6'd0;
    else cap = WIN_W'($urandom_range(1, 63));
    if ($urandom_range(99) < 80) init = WIN_W'($urandom_range(1, (cap == '0) ? 1 : cap));
    else init = WIN_W'($urandom_range(0, 63));
    configure(fbytes, mss, HDR_W'($urandom_range(0, 255)), cap, init,
              MODE_W'($urandom_range(0, 3)), QOS_W'($urandom_range(0, 255)));
    post(REQ_START, $urandom);
    n_ev = $urandom_range(8, 40);
    repeat (n_ev) begin
      r = $urandom_range(99);
      if (r < 8 || sent_end <= acked) begin
        post(REQ_TIMEOUT, $urandom);
      end else if (r < 11) begin
        post(REQ_ACK, $urandom);
      end else if (r < 14) begin
        post(REQ_ACK, SEQ_W'(acked));
      end else if (r < 15) begin
        post(REQ_UNUSED, $urandom);
      end else if (r < 16) begin
        post(REQ_START, $urandom);
      end else begin
        span = sent_end - acked;
        k    = int'((span + seg_size - 1) / seg_size);
        ack  = acked + seg_size * $urandom_range(1, k);
        if (ack > sent_end) ack = sent_end;
        post(REQ_ACK, SEQ_W'(ack));
      end
      if (acked == 64'(flow_size)) break;
    end
    post(REQ_ACK, flow_size);
    post(REQ_ACK, flow_size);
    settle();
  endtask

  initial begin
    int unsigned base;
    int unsigned phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_reg(CFG_UNUSED, '1);
    cfg_valid <= 1'b0;
    post(REQ_START, '0);
    post(REQ_ACK, '0);
    post(REQ_ACK, 32'd1);
    post(REQ_ACK, 32'd1);
    post(REQ_TIMEOUT, '0);
    post(REQ_UNUSED, '1);
    settle();

    configure('1, '1, '1, 6'd63, 6'd63, PM_REMAINING, '1);
    post(REQ_START, '1);
    post(REQ_ACK, 32'd16383);
    post(REQ_TIMEOUT, '0);
    post(REQ_ACK, '1);
    post(REQ_UNUSED, '0);
    settle();

    configure(32'd12, '0, '0, '0, '0, PM_THRESHOLD, '0);
    post(REQ_START, '0);
    post(REQ_ACK, 32'd5);
    post(REQ_TIMEOUT, '0);
    settle();

    configure(32'd12, '0, '0, 6'd63, 6'd4, PM_QOS, 8'hAA);
    post(REQ_START, '0);
    post(REQ_ACK, 32'd2);
    settle();

    configure(32'd4097, 14'd1, '0, 6'd2, 6'd2, PM_THRESHOLD, '0);
    post(REQ_START, '0);
    post(REQ_ACK, 32'd1);
    settle();

    configure(32'd300000, 14'd9000, 8'd40, 6'd5, 6'd1, PM_THRESHOLD, '0);
    post(REQ_START, '0);
    post(REQ_ACK, 32'd9000);
    post(REQ_TIMEOUT, '0);
    settle();
    configure(32'd300000, 14'd9000, 8'd40, 6'd5, 6'd1, PM_ONE, '0);
    post(REQ_START, '0);
    settle();

    base  = events_sent;
    phase = 0;
    while (events_sent - base < RANDOM_EVENTS) begin
      if (phase == 3 || phase == 4) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 32;
        out_idle_pct = 32;
      end
      run_flow();
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
